// ===== rtl/rip_pkg.sv =====
`timescale 1ns / 1ps

package rip_pkg;

  // scan sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } rip_state_t;

  // control from sequencer to the row-end memory
  typedef struct packed {
    logic rd;
    logic wr;
  } rip_mem_ctl_t;

  // fixed field widths
  localparam int COORD_W = 32;
  localparam int IDX_OUT_W = 4;
  localparam int CFG_W = 5;

  // register reset value for the active row count
  localparam logic [CFG_W-1:0] ROWS_RESET = 5'd16;

endpackage

// ===== rtl/interval_row_placer_top.sv =====
`timescale 1ns / 1ps
// channel | handshake             | payload
// input   | in_valid / in_stall   | interval_start, interval_end (signed Q16.16)
// result  | out_valid / out_stall | row_index
// config  | cfg_valid / cfg_ready | rows_in_use
//
// an item passes through the accepting cycle, k row compares and the write-back.
// k is the position of the first row that fits, at most the active row count
// n (1 .. MAX_ROWS); no new input is taken until the item's write-back is done.
// the next item can be taken in the cycle after the write-back; a waiting result sits
// in the output register and only holds off the write-back of the following item.
// reset is synchronous; all row ends read as zero afterwards (per-row flags).

module interval_row_placer_top
  import rip_pkg::*;
#(
  parameter int MAX_ROWS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] interval_start,
  input  logic signed [COORD_W-1:0] interval_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [IDX_OUT_W-1:0]      row_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          rows_in_use
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [CFG_W-1:0]   rows_cfg;
  rip_mem_ctl_t       mem_ctl;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [COORD_W-1:0] wr_data;
  logic [COORD_W-1:0] rd_data;

  // configuration register, always ready for a transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rows_cfg <= rows_in_use;
    end
  end

  rip_scan #(
    .MAX_ROWS(MAX_ROWS),
    .AW(AW)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .interval_start(interval_start),
    .interval_end  (interval_end),
    .rows_in_use   (rows_cfg),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_index     (row_index),
    .mem_ctl       (mem_ctl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_data       (rd_data)
  );

  rip_row_mem #(
    .DEPTH(MAX_ROWS),
    .AW(AW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

endmodule

// ===== rtl/rip_row_mem.sv =====
`timescale 1ns / 1ps

module rip_row_mem
  import rip_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  rip_mem_ctl_t        ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [COORD_W-1:0]  wr_data,
  output logic [COORD_W-1:0]  rd_data
);

  logic [COORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  logic [COORD_W-1:0] rd_q;
  logic               rd_vld;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // per-row written flags, rows never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== rtl/rip_scan.sv =====
`timescale 1ns / 1ps

module rip_scan
  import rip_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int AW = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  interval_start,
  input  logic signed [COORD_W-1:0]  interval_end,
  input  logic [CFG_W-1:0]           rows_in_use,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [IDX_OUT_W-1:0]       row_index,
  output rip_mem_ctl_t               mem_ctl,
  output logic [AW-1:0]              rd_addr,
  output logic [AW-1:0]              wr_addr,
  output logic [COORD_W-1:0]         wr_data,
  input  logic [COORD_W-1:0]         rd_data
);

  localparam int CW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;

  rip_state_t                 state, state_next;
  logic signed [COORD_W-1:0]  start_coord;
  logic [COORD_W-1:0]         end_coord;
  logic [AW-1:0]              cmp_idx, cmp_idx_next;
  logic [AW-1:0]              best_idx, best_idx_next;
  logic signed [COORD_W-1:0]  best_end, best_end_next;
  logic                       have_best, have_best_next;
  logic [AW-1:0]              chosen, chosen_next;
  logic [CW-1:0]              n_clip;
  logic [CW-1:0]              n_last;
  logic [AW-1:0]              last;
  logic signed [COORD_W-1:0]  row_val;
  logic                       fits;
  logic                       better;
  logic                       accept;
  logic                       out_free;
  logic [AW+IDX_OUT_W-1:0]    idx_ext;

  // effective row count: zero counts as one, clipped to the built depth
  always_comb begin
    n_clip = CW'(rows_in_use);
    if (n_clip == '0) begin
      n_clip = CW'(1);
    end
    if (n_clip > CW'(MAX_ROWS)) begin
      n_clip = CW'(MAX_ROWS);
    end
    n_last = n_clip - CW'(1);
    last   = n_last[AW-1:0];
  end

  // row compare against the latched interval
  assign row_val  = $signed(rd_data);
  assign fits     = row_val < start_coord;
  assign better   = !have_best || (row_val < best_end);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // sequencer next state and memory control
  always_comb begin
    state_next     = state;
    cmp_idx_next   = cmp_idx;
    best_idx_next  = best_idx;
    best_end_next  = best_end;
    have_best_next = have_best;
    chosen_next    = chosen;
    mem_ctl        = '0;
    rd_addr        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mem_ctl.rd     = 1'b1;
          rd_addr        = '0;
          cmp_idx_next   = '0;
          have_best_next = 1'b0;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (fits) begin
          chosen_next = cmp_idx;
          state_next  = ST_WRITE;
        end else if (cmp_idx == last) begin
          chosen_next = better ? cmp_idx : best_idx;
          state_next  = ST_WRITE;
        end else begin
          if (better) begin
            best_idx_next = cmp_idx;
            best_end_next = row_val;
          end
          have_best_next = 1'b1;
          cmp_idx_next   = cmp_idx + AW'(1);
          mem_ctl.rd     = 1'b1;
          rd_addr        = cmp_idx + AW'(1);
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          mem_ctl.wr = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign wr_addr = chosen;
  assign wr_data = end_coord;
  assign idx_ext = {{IDX_OUT_W{1'b0}}, chosen};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      start_coord <= interval_start;
      end_coord   <= interval_end;
    end
    cmp_idx   <= cmp_idx_next;
    best_idx  <= best_idx_next;
    best_end  <= best_end_next;
    have_best <= have_best_next;
    chosen    <= chosen_next;
  end

  // result register, decouples the result transfer from the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      row_index <= idx_ext[IDX_OUT_W-1:0];
    end
  end

endmodule

// ===== rtl/rip_checker.sv =====
`timescale 1ns / 1ps

module rip_checker
  import rip_pkg::*;
#(
  parameter int MAX_ROWS = 16
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [IDX_OUT_W-1:0]      row_index
);

  // no result is pending straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time: an input transfer closes the input side next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(row_index)))
    else $error("stalled result changed");

  // the chosen row lies inside the built rows
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((MAX_ROWS > 15) || (int'(row_index) < MAX_ROWS)))
    else $error("row index beyond built rows");

endmodule

bind interval_row_placer_top rip_checker #(.MAX_ROWS(MAX_ROWS)) u_chk (.*);
